// ===== hdl/sfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfs_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_FRAMES_DEF = 64;
	localparam int TIME_BITS_DEF  = 24;

	// Fixed field widths.
	localparam int FRAME_W   = 7;
	localparam int IDX_W     = 6;
	localparam int VALUE_W   = 24;
	localparam int PASS_W    = 8;
	localparam int STEP_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	// Item modes.
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_WR_MAIN  = 2'd1;
	localparam logic [1:0] MODE_WR_REP   = 2'd2;
	localparam logic [1:0] MODE_RESTART  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_START   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_END     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FOREVER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_TARGET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd6;

	// Configuration reset values.
	localparam logic [IDX_W-1:0]  RST_MAIN_START   = 6'd0;
	localparam logic [IDX_W-1:0]  RST_MAIN_END     = 6'd63;
	localparam logic [IDX_W-1:0]  RST_REPEAT_START = 6'd63;
	localparam logic [IDX_W-1:0]  RST_REPEAT_END   = 6'd63;
	localparam logic              RST_LOOP_FOREVER = 1'b0;
	localparam logic [PASS_W-1:0] RST_PASS_TARGET  = 8'd1;
	localparam logic [STEP_W-1:0] RST_TIME_STEP    = 16'd16667;

	localparam logic [PASS_W-1:0] PASS_MAX = 8'd255;

endpackage
`default_nettype wire

// ===== hdl/sfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/sprite_frame_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Animation frame sequencer.
// Input beats (in_valid/in_ready) carry a mode: a tick, a write of one entry of
// the main or repeat interval table, or a restart of the run. Only a tick makes
// an output beat (out_valid/out_ready) with the frame to show, the hold flag,
// the cycle flag and the pass count. Table writes and restarts make no beat.
// A tick's result sits in the output register on the cycle after acceptance.
// One item is taken every cycle unless the receiver stalls. Each interval table is
// a one-port-write RAM with a registered read; the read address is formed from
// the next-state frame, so the interval for the coming tick is always waiting
// in the RAM output, and a table write to that very entry is forwarded.
// When the receiver stalls, the output register holds its beat and in_ready
// drops until it is taken; an item arriving while the beat leaves is taken in
// the same cycle. Reset restores the configuration defaults and clears the run
// state; the table contents are not cleared and must be written before use.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module sprite_frame_sequencer_core
	import sfs_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           mode,
	input  wire logic [IDX_W-1:0]     entry_index,
	input  wire logic [VALUE_W-1:0]   entry_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [IDX_W-1:0]     frame_index,
	output logic                      frame_held,
	output logic                      cycle_flag,
	output logic      [PASS_W-1:0]    passes_done
);

	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int OW = (AW > FRAME_W) ? AW : FRAME_W;
	localparam int SW = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;
	localparam logic [SW-1:0] TMAX = SW'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [OW-1:0] DEPTH_O = OW'(MAX_FRAMES);

	// Configuration registers.
	logic [IDX_W-1:0]  main_start_q, main_end_q, repeat_start_q, repeat_end_q;
	logic              loop_forever_q;
	logic [PASS_W-1:0] pass_target_q;
	logic [STEP_W-1:0] time_step_q;
	logic [IDX_W-1:0]  main_start_d, repeat_start_d;

	// Run state.
	logic [TIME_BITS-1:0] elapsed_q, n_elapsed;
	logic [FRAME_W-1:0]   frame_q, n_frame;
	logic [PASS_W-1:0]    pass_q, n_pass;
	logic                 rep_q, n_rep, hold_q, n_hold;
	logic [FRAME_W-1:0]   shown;

	// Table read side.
	logic [TIME_BITS-1:0] rd_main, rd_rep;
	logic                 oor_m_q, oor_r_q, byp_m_q, byp_r_q;
	logic [TIME_BITS-1:0] byp_data_q;
	logic [OW-1:0]        off_m, off_r, wr_off;
	logic                 wr_ok, we_m, we_r;
	logic [TIME_BITS-1:0] wr_val, iv_main, iv_rep, interval;

	// Output register.
	logic              out_valid_q;
	logic [IDX_W-1:0]  frame_index_q;
	logic              frame_held_q, cycle_flag_q;
	logic [PASS_W-1:0] passes_done_q;

	logic accept, tick;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign tick     = accept && (mode == MODE_TICK);

	assign main_start_d   = (cfg_we && cfg_index == CFG_MAIN_START)
	                        ? cfg_data[IDX_W-1:0] : main_start_q;
	assign repeat_start_d = (cfg_we && cfg_index == CFG_REPEAT_START)
	                        ? cfg_data[IDX_W-1:0] : repeat_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_start_q   <= RST_MAIN_START;
			main_end_q     <= RST_MAIN_END;
			repeat_start_q <= RST_REPEAT_START;
			repeat_end_q   <= RST_REPEAT_END;
			loop_forever_q <= RST_LOOP_FOREVER;
			pass_target_q  <= RST_PASS_TARGET;
			time_step_q    <= RST_TIME_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAIN_START:   main_start_q   <= cfg_data[IDX_W-1:0];
				CFG_MAIN_END:     main_end_q     <= cfg_data[IDX_W-1:0];
				CFG_REPEAT_START: repeat_start_q <= cfg_data[IDX_W-1:0];
				CFG_REPEAT_END:   repeat_end_q   <= cfg_data[IDX_W-1:0];
				CFG_LOOP_FOREVER: loop_forever_q <= cfg_data[0];
				CFG_PASS_TARGET:  pass_target_q  <= cfg_data[PASS_W-1:0];
				CFG_TIME_STEP:    time_step_q    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Interval of the current frame, from the table the run is in.
	assign iv_main  = oor_m_q ? '0 : (byp_m_q ? byp_data_q : rd_main);
	assign iv_rep   = oor_r_q ? '0 : (byp_r_q ? byp_data_q : rd_rep);
	assign interval = (rep_q && !loop_forever_q) ? iv_rep : iv_main;

	always_comb begin
		logic [SW-1:0]     sum;
		logic [PASS_W-1:0] pc;
		n_elapsed = elapsed_q;
		n_frame   = frame_q;
		n_pass    = pass_q;
		n_rep     = rep_q;
		n_hold    = hold_q;
		shown     = frame_q;
		sum       = SW'(elapsed_q) + SW'(time_step_q);
		pc        = (pass_q == PASS_MAX) ? pass_q : pass_q + 1'b1;
		if (accept && mode == MODE_RESTART) begin
			n_elapsed = '0;
			n_frame   = {1'b0, main_start_q};
			n_pass    = '0;
			n_rep     = 1'b0;
			n_hold    = 1'b0;
		end else if (tick) begin
			n_elapsed = (sum > TMAX) ? TMAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];
			if (n_elapsed >= interval) begin
				n_elapsed = '0;
				n_frame   = frame_q + 1'b1;
			end
			if (!loop_forever_q) begin
				if (rep_q) begin
					if (n_frame == {1'b0, repeat_end_q}) begin
						n_hold = 1'b1;
					end else if (n_frame > {1'b0, repeat_end_q}) begin
						n_frame = {1'b0, repeat_start_q};
						n_hold  = 1'b0;
					end
				end else if (n_frame == {1'b0, main_end_q}) begin
					n_hold = 1'b1;
				end else if (n_frame > {1'b0, main_end_q}) begin
					n_pass = pc;
					n_hold = 1'b0;
					if (pc >= pass_target_q) begin
						n_rep   = 1'b1;
						n_frame = {1'b0, repeat_start_q};
					end else begin
						n_frame = {1'b0, main_start_q};
					end
				end
				shown = n_frame;
			end else begin
				n_rep = 1'b0;
				shown = n_frame;
				if (n_frame == {1'b0, main_end_q}) begin
					n_hold = 1'b1;
				end else if (n_frame > {1'b0, main_end_q}) begin
					n_frame = {1'b0, main_start_q};
					n_pass  = pc;
					n_hold  = 1'b0;
					n_rep   = 1'b1;
					shown   = {1'b0, main_end_q};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			frame_q   <= {1'b0, RST_MAIN_START};
			pass_q    <= '0;
			rep_q     <= 1'b0;
			hold_q    <= 1'b0;
		end else begin
			elapsed_q <= n_elapsed;
			frame_q   <= n_frame;
			pass_q    <= n_pass;
			rep_q     <= n_rep;
			hold_q    <= n_hold;
		end
	end

	// Read offsets follow the next-state frame, so the RAM output lines up
	// with the state register on the following cycle.
	assign off_m  = OW'(FRAME_W'(n_frame - {1'b0, main_start_d}));
	assign off_r  = OW'(FRAME_W'(n_frame - {1'b0, repeat_start_d}));
	assign wr_off = OW'(entry_index);
	assign wr_ok  = wr_off < DEPTH_O;
	assign wr_val = TIME_BITS'(entry_value);
	assign we_m   = accept && (mode == MODE_WR_MAIN) && wr_ok;
	assign we_r   = accept && (mode == MODE_WR_REP) && wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_m_q <= 1'b1;
			oor_r_q <= 1'b1;
			byp_m_q <= 1'b0;
			byp_r_q <= 1'b0;
		end else begin
			oor_m_q <= off_m >= DEPTH_O;
			oor_r_q <= off_r >= DEPTH_O;
			byp_m_q <= we_m && (wr_off == off_m);
			byp_r_q <= we_r && (wr_off == off_r);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr_val;
	end

	sfs_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_FRAMES)
	) u_main_ram (
		.clk   (clk),
		.we    (we_m),
		.waddr (wr_off[AW-1:0]),
		.wdata (wr_val),
		.raddr (off_m[AW-1:0]),
		.rdata (rd_main)
	);

	sfs_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_FRAMES)
	) u_rep_ram (
		.clk   (clk),
		.we    (we_r),
		.waddr (wr_off[AW-1:0]),
		.wdata (wr_val),
		.raddr (off_r[AW-1:0]),
		.rdata (rd_rep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			frame_index_q <= shown[IDX_W-1:0];
			frame_held_q  <= n_hold;
			cycle_flag_q  <= n_rep;
			passes_done_q <= n_pass;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_index = frame_index_q;
	assign frame_held  = frame_held_q;
	assign cycle_flag  = cycle_flag_q;
	assign passes_done = passes_done_q;

endmodule
`default_nettype wire

// ===== tb/sv/sfs_frame_checker.sv =====
`timescale 1ns / 1ps
module sfs_frame_checker
	import sfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic [VALUE_W-1:0]   entry_value,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [IDX_W-1:0]     frame_index,
	input  logic                 frame_held,
	input  logic                 cycle_flag,
	input  logic [PASS_W-1:0]    passes_done,
	output int                   errors,
	output int                   pending,
	output int                   ticks_checked
);

	typedef struct packed {
		logic [IDX_W-1:0]  frame_index;
		logic              held;
		logic              cycle;
		logic [PASS_W-1:0] passes;
	} frame_result_t;

	frame_result_t expected_frames[$];

	// Register copies.
	logic [IDX_W-1:0]  c_main_start, c_main_end, c_rep_start, c_rep_end;
	logic              c_loop;
	logic [PASS_W-1:0] c_pass_target;
	logic [STEP_W-1:0] c_step;

	// Run state.
	logic [VALUE_W-1:0] elapsed;
	logic [FRAME_W-1:0] frame;
	logic [PASS_W-1:0]  passes;
	logic               in_tail;
	logic               held;
	logic [VALUE_W-1:0] main_tbl [64];
	logic [VALUE_W-1:0] tail_tbl [64];

	initial begin
		errors = 0;
		pending = 0;
		ticks_checked = 0;
	end

	task automatic restart_run();
		elapsed = '0;
		frame = {1'b0, c_main_start};
		passes = '0;
		in_tail = 1'b0;
		held = 1'b0;
	endtask

	task automatic count_pass();
		if (passes != PASS_MAX)
			passes = passes + 1'b1;
	endtask

	// The table offset wraps at 128 frames; offsets past the table read as zero.
	function automatic logic [VALUE_W-1:0] interval_now(input logic from_tail);
		logic [FRAME_W-1:0] off;
		off = frame - {1'b0, from_tail ? c_rep_start : c_main_start};
		if (off[FRAME_W-1])
			return '0;
		return from_tail ? tail_tbl[off[IDX_W-1:0]] : main_tbl[off[IDX_W-1:0]];
	endfunction

	task automatic advance_tick(output frame_result_t r);
		logic [VALUE_W:0]   sum;
		logic [VALUE_W-1:0] ivl;
		logic [FRAME_W-1:0] shown;
		sum = {1'b0, elapsed} + c_step;
		elapsed = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
		ivl = interval_now(in_tail && !c_loop);
		if (elapsed >= ivl) begin
			elapsed = '0;
			frame = frame + 1'b1;
		end
		shown = frame;
		if (!c_loop) begin
			if (in_tail) begin
				if (frame == c_rep_end) begin
					held = 1'b1;
				end else if (frame > c_rep_end) begin
					frame = {1'b0, c_rep_start};
					held = 1'b0;
				end
			end else if (frame == c_main_end) begin
				held = 1'b1;
			end else if (frame > c_main_end) begin
				frame = {1'b0, c_main_start};
				count_pass();
				if (passes >= c_pass_target) begin
					in_tail = 1'b1;
					frame = {1'b0, c_rep_start};
				end
				held = 1'b0;
			end
			shown = frame;
		end else begin
			// In loop mode the cycle flag is only a pulse on the wrapping tick,
			// and that tick still shows the end frame.
			in_tail = 1'b0;
			if (frame == c_main_end) begin
				held = 1'b1;
			end else if (frame > c_main_end) begin
				frame = {1'b0, c_main_start};
				count_pass();
				held = 1'b0;
				in_tail = 1'b1;
				shown = {1'b0, c_main_end};
			end
		end
		r.frame_index = shown[IDX_W-1:0];
		r.held = held;
		r.cycle = in_tail;
		r.passes = passes;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		frame_result_t got;
		if (!arst_n) begin
			c_main_start = RST_MAIN_START;
			c_main_end = RST_MAIN_END;
			c_rep_start = RST_REPEAT_START;
			c_rep_end = RST_REPEAT_END;
			c_loop = RST_LOOP_FOREVER;
			c_pass_target = RST_PASS_TARGET;
			c_step = RST_TIME_STEP;
			restart_run();
			expected_frames.delete();
			pending = 0;
		end else begin
			// Retire the outgoing beat before the incoming one is predicted.
			if (out_valid && out_ready) begin
				got.frame_index = frame_index;
				got.held = frame_held;
				got.cycle = cycle_flag;
				got.passes = passes_done;
				if (expected_frames.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result beat, expected none, got frame %0d",
						$time, frame_index);
				end else begin
					want = expected_frames.pop_front();
					check_field("frame_index", want.frame_index, got.frame_index);
					check_field("frame_held", want.held, got.held);
					check_field("cycle_flag", want.cycle, got.cycle);
					check_field("passes_done", want.passes, got.passes);
					ticks_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAIN_START:   c_main_start = cfg_data[IDX_W-1:0];
					CFG_MAIN_END:     c_main_end = cfg_data[IDX_W-1:0];
					CFG_REPEAT_START: c_rep_start = cfg_data[IDX_W-1:0];
					CFG_REPEAT_END:   c_rep_end = cfg_data[IDX_W-1:0];
					CFG_LOOP_FOREVER: c_loop = cfg_data[0];
					CFG_PASS_TARGET:  c_pass_target = cfg_data[PASS_W-1:0];
					CFG_TIME_STEP:    c_step = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (mode)
					MODE_WR_MAIN: main_tbl[entry_index] = entry_value;
					MODE_WR_REP:  tail_tbl[entry_index] = entry_value;
					MODE_RESTART: restart_run();
					default: begin
						advance_tick(want);
						expected_frames.push_back(want);
					end
				endcase
			end
			pending = expected_frames.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import sfs_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic [1:0]           mode = MODE_TICK;
	logic [IDX_W-1:0]     entry_index = '0;
	logic [VALUE_W-1:0]   entry_value = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [IDX_W-1:0]     frame_index;
	logic                 frame_held;
	logic                 cycle_flag;
	logic [PASS_W-1:0]    passes_done;

	int fail_count;
	int pending;
	int ticks_checked;
	int idle_cycles = 0;
	int items_sent = 0;
	int settings_used = 0;
	bit steady_flow = 1'b0;
	logic [STEP_W-1:0] cur_step = RST_TIME_STEP;

	sprite_frame_sequencer_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .entry_index(entry_index), .entry_value(entry_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_index(frame_index), .frame_held(frame_held),
		.cycle_flag(cycle_flag), .passes_done(passes_done)
	);

	sfs_frame_checker frame_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .entry_index(entry_index), .entry_value(entry_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_index(frame_index), .frame_held(frame_held),
		.cycle_flag(cycle_flag), .passes_done(passes_done),
		.errors(fail_count), .pending(pending), .ticks_checked(ticks_checked)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= steady_flow || ($urandom_range(0, 99) >= 29);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Intervals are scaled to the time step so that frames actually move.
	function automatic logic [VALUE_W-1:0] pick_interval();
		int unsigned base;
		int unsigned r;
		base = (cur_step == 0) ? 1 : cur_step;
		r = $urandom_range(0, 99);
		if (cur_step == 0)
			return (r < 70) ? '0 : VALUE_W'($urandom_range(1, 1000));
		if (r < 10)
			return '0;
		if (r < 75)
			return VALUE_W'($urandom_range(0, 3 * base));
		if (r < 95)
			return VALUE_W'($urandom_range(base, 12 * base));
		return VALUE_W'($urandom_range(0, 40 * base));
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [IDX_W-1:0] idx,
		input logic [VALUE_W-1:0] val);
		while (!steady_flow && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [IDX_W-1:0] ms, input logic [IDX_W-1:0] me,
		input logic [IDX_W-1:0] rs, input logic [IDX_W-1:0] re, input logic lf,
		input logic [PASS_W-1:0] pt, input logic [STEP_W-1:0] ts);
		// Writes and restarts make no beat, so give the block a few spare cycles.
		wait_results();
		repeat (4) @(negedge clk);
		put_reg(CFG_MAIN_START, CFG_W'(ms));
		put_reg(CFG_MAIN_END, CFG_W'(me));
		put_reg(CFG_REPEAT_START, CFG_W'(rs));
		put_reg(CFG_REPEAT_END, CFG_W'(re));
		put_reg(CFG_LOOP_FOREVER, CFG_W'(lf));
		put_reg(CFG_PASS_TARGET, CFG_W'(pt));
		put_reg(CFG_TIME_STEP, CFG_W'(ts));
		cfg_we <= 1'b0;
		cur_step = ts;
		settings_used++;
	endtask

	task automatic random_setting();
		int unsigned ms, me, rs, re, pt, ts, r;
		ms = $urandom_range(0, 63);
		r = $urandom_range(0, 99);
		me = (r < 70) ? ms + $urandom_range(0, 5) : $urandom_range(0, 63);
		if (me > 63)
			me = 63;
		rs = $urandom_range(0, 63);
		r = $urandom_range(0, 99);
		re = (r < 70) ? rs + $urandom_range(0, 5) : $urandom_range(0, 63);
		if (re > 63)
			re = 63;
		r = $urandom_range(0, 99);
		pt = (r < 25) ? 0 : (r < 35) ? 255 : $urandom_range(1, 4);
		r = $urandom_range(0, 99);
		ts = (r < 15) ? 0 : (r < 30) ? 65535 : $urandom_range(1, 65535);
		set_config(IDX_W'(ms), IDX_W'(me), IDX_W'(rs), IDX_W'(re),
			1'($urandom_range(0, 1)), PASS_W'(pt), STEP_W'(ts));
	endtask

	task automatic random_run(input int n);
		int r;
		logic [1:0] m;
		logic [IDX_W-1:0] idx;
		logic [VALUE_W-1:0] val;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			m = (r < 72) ? MODE_TICK : (r < 83) ? MODE_WR_MAIN :
				(r < 94) ? MODE_WR_REP : (r < 97) ? MODE_RESTART : MODE_TICK;
			// Table entries near the start of a range are the ones in use.
			idx = ($urandom_range(0, 9) < 6) ? IDX_W'($urandom_range(0, 7))
				: IDX_W'($urandom_range(0, 63));
			val = ($urandom_range(0, 19) == 0) ? VALUE_W'($urandom) : pick_interval();
			if ($urandom_range(0, 119) == 0)
				wait_results();
			send_item(m, idx, val);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Both tables are filled first so that no entry is ever read unwritten.
		for (int i = 0; i < 64; i++) begin
			send_item(MODE_WR_MAIN, IDX_W'(i), pick_interval());
			send_item(MODE_WR_REP, IDX_W'(i), pick_interval());
		end
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_TICK, '1, '1);

		// Short ranges with two passes before the tail range takes over.
		set_config(6'd2, 6'd4, 6'd10, 6'd11, 1'b0, 8'd2, 16'd100);
		send_item(MODE_WR_MAIN, 6'd0, 24'd0);
		send_item(MODE_WR_MAIN, 6'd1, 24'd100);
		send_item(MODE_WR_MAIN, 6'd2, 24'd250);
		send_item(MODE_WR_REP, 6'd0, 24'd0);
		send_item(MODE_WR_REP, 6'd1, 24'd50);
		send_item(MODE_WR_REP, 6'd63, 24'hFFFFFF);
		send_item(MODE_WR_MAIN, 6'd63, 24'hFFFFFF);
		send_item(MODE_RESTART, '0, '0);
		repeat (12) send_item(MODE_TICK, '0, '0);

		// Zero pass target, then inverted ranges in both modes.
		set_config(6'd5, 6'd7, 6'd20, 6'd22, 1'b0, 8'd0, 16'd1000);
		send_item(MODE_RESTART, '0, '0);
		random_run(50);
		set_config(6'd40, 6'd10, 6'd50, 6'd30, 1'b1, 8'd3, 16'd5000);
		send_item(MODE_RESTART, '0, '0);
		random_run(50);
		set_config(6'd0, 6'd2, 6'd30, 6'd20, 1'b0, 8'd1, 16'd3000);
		send_item(MODE_RESTART, '0, '0);
		random_run(50);

		// Largest step against the largest interval drives elapsed time into
		// saturation; this stretch also runs with no idling on either side.
		set_config(6'd0, 6'd1, 6'd63, 6'd63, 1'b0, 8'd1, 16'hFFFF);
		send_item(MODE_WR_MAIN, 6'd0, 24'hFFFFFF);
		send_item(MODE_RESTART, '0, '0);
		steady_flow = 1'b1;
		repeat (262) send_item(MODE_TICK, '0, '0);
		steady_flow = 1'b0;

		// One-frame loop with zero interval wraps on every tick, so the pass
		// count runs into its ceiling.
		set_config(6'd7, 6'd7, 6'd0, 6'd63, 1'b1, 8'd255, 16'd0);
		send_item(MODE_WR_MAIN, 6'd0, 24'd0);
		send_item(MODE_RESTART, '0, '0);
		repeat (270) send_item(MODE_TICK, '0, '0);

		for (int p = 0; p < 5; p++) begin
			random_setting();
			if ($urandom_range(0, 9) < 7)
				send_item(MODE_RESTART, '0, '0);
			random_run(60);
		end

		wait_results();
		repeat (10) @(negedge clk);
		$display("Covered %0d items and %0d checked ticks over %0d register settings,",
			items_sent, ticks_checked, settings_used);
		$display("with counted, looping, inverted-range and saturating runs.");
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
